@@ rtl/cjs_pkg.sv @@
// Shared types and constants for the CPU job scheduler simulator.
// No dependencies.
package cjs_pkg;
    localparam int MAX_JOBS = 16;
    localparam int IDX_W    = $clog2(MAX_JOBS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    localparam int TIME_W   = 23;
    localparam logic [TIME_W-1:0] TMAX = {TIME_W{1'b1}};

    localparam logic [0:0] REG_POLICY  = 1'b0;
    localparam logic [0:0] REG_QUANTUM = 1'b1;

    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_SJF  = 2'd1;
    localparam logic [1:0] MODE_SRTF = 2'd2;
    localparam logic [1:0] MODE_RR   = 2'd3;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_SCAN,
        ST_DECIDE,
        ST_RR_ADMIT,
        ST_RR_POP,
        ST_RR_RUN,
        ST_RR_PUSH,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_SEND
    } state_t;

    typedef struct packed {
        logic [5:0]  id;
        logic [15:0] arrival;
        logic [15:0] burst;
    } job_t;
endpackage

@@ rtl/cjs_job_ram.sv @@
// Per-job record store: id, arrival, burst, remaining, finish.
// Depends on cjs_pkg. One write port, one registered read port.
module cjs_job_ram (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [cjs_pkg::IDX_W-1:0]  wr_addr,
    input  cjs_pkg::job_t              wr_job,
    input  logic [15:0]                wr_rem,
    input  logic [cjs_pkg::TIME_W-1:0] wr_fin,
    input  logic [cjs_pkg::IDX_W-1:0]  rd_addr,
    output cjs_pkg::job_t              rd_job,
    output logic [15:0]                rd_rem,
    output logic [cjs_pkg::TIME_W-1:0] rd_fin
);
    cjs_pkg::job_t              job_mem [cjs_pkg::MAX_JOBS];
    logic [15:0]                rem_mem [cjs_pkg::MAX_JOBS];
    logic [cjs_pkg::TIME_W-1:0] fin_mem [cjs_pkg::MAX_JOBS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            job_mem[wr_addr] <= wr_job;
            rem_mem[wr_addr] <= wr_rem;
            fin_mem[wr_addr] <= wr_fin;
        end
        rd_job <= job_mem[rd_addr];
        rd_rem <= rem_mem[rd_addr];
        rd_fin <= fin_mem[rd_addr];
    end
endmodule

@@ rtl/cjs_ring_ram.sv @@
// Round robin ready ring store of job indexes.
// Depends on cjs_pkg. One write port, one registered read port.
module cjs_ring_ram (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [cjs_pkg::IDX_W-1:0] wr_addr,
    input  logic [cjs_pkg::IDX_W-1:0] wr_data,
    input  logic [cjs_pkg::IDX_W-1:0] rd_addr,
    output logic [cjs_pkg::IDX_W-1:0] rd_data
);
    logic [cjs_pkg::IDX_W-1:0] mem [cjs_pkg::MAX_JOBS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

@@ rtl/cpu_job_scheduler_sim.sv @@
// Top level of the CPU job scheduler simulator: load, scheduling sequencer, output.
// Depends on cjs_pkg, cjs_job_ram and cjs_ring_ram.
//
// Jobs load at one per cycle into the job record memory. The transfer with
// tlast starts the simulation, which walks the memory one entry per cycle:
// each scheduling decision scans the n loaded jobs and then updates the pick's
// record, and round robin slices add a scan per admission check. Results
// then leave in load order, each read and registered before it is offered.
// No input is taken while a set is simulated or its results are sent.
module cpu_job_scheduler_sim (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // job_id[5:0], arrival_time[21:6], burst_time[37:22]
    input  logic        s_tlast,  // last_job
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // result_job_id[5:0], turnaround[28:6], waiting[51:29]
    output logic        m_tlast   // last_result
);
    localparam int IW = cjs_pkg::IDX_W;
    localparam int CW = cjs_pkg::CNT_W;
    localparam int TW = cjs_pkg::TIME_W;

    cjs_pkg::state_t state_reg, state_next;
    logic [1:0]  mode_reg;
    logic [15:0] quantum_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [TW-1:0] clock_reg, clock_next;
    logic [cjs_pkg::MAX_JOBS-1:0] done_reg, done_next, adm_reg, adm_next;
    logic [CW-1:0] left_reg, left_next;
    logic [CW-1:0] scan_reg, scan_next;   // read address counter
    logic          vld_reg, vld_next;     // read data valid this cycle
    logic [IW-1:0] vidx_reg, vidx_next;   // index of data now out of RAM
    logic          pick_ok_reg, pick_ok_next;
    logic [IW-1:0] pick_reg, pick_next;
    logic [16:0]   key_reg, key_next;
    logic          na_ok_reg, na_ok_next;
    logic [15:0]   na_reg, na_next;       // earliest pending arrival
    logic [IW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [15:0]   crem_reg, crem_next;

    logic          jw_en;
    logic [IW-1:0] jw_addr, jr_addr;
    cjs_pkg::job_t jw_job, jr_job;
    logic [15:0]   jw_rem, jr_rem;
    logic [TW-1:0] jw_fin, jr_fin;
    logic          rw_en;
    logic [IW-1:0] rw_addr, rw_data, rr_addr, rr_data;

    cjs_job_ram u_job (
        .aclk(aclk), .wr_en(jw_en), .wr_addr(jw_addr), .wr_job(jw_job),
        .wr_rem(jw_rem), .wr_fin(jw_fin), .rd_addr(jr_addr),
        .rd_job(jr_job), .rd_rem(jr_rem), .rd_fin(jr_fin)
    );
    cjs_ring_ram u_ring (
        .aclk(aclk), .wr_en(rw_en), .wr_addr(rw_addr), .wr_data(rw_data),
        .rd_addr(rr_addr), .rd_data(rr_data)
    );

    logic [TW-1:0] out_ta_reg, out_wt_reg;
    logic [TW-1:0] ta_c, wt_c;
    logic [16:0]   k_c;
    logic [TW-1:0] arr_c, run_c, qrun_c;
    logic [TW:0]   sum_c;
    logic [15:0]   q_c;
    logic          elig_c;
    logic          out_tlast_reg;
    logic [5:0]    out_id_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= cjs_pkg::MODE_FCFS;
            quantum_reg <= 16'd1;
        end else if (cfg_we) begin
            case (cfg_index)
                cjs_pkg::REG_POLICY:  mode_reg    <= cfg_wdata[1:0];
                cjs_pkg::REG_QUANTUM: quantum_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cjs_pkg::ST_LOAD;
            count_reg <= '0;
            clock_reg <= '0;
            done_reg  <= '0;
            adm_reg   <= '0;
            left_reg  <= '0;
            scan_reg  <= '0;
            vld_reg   <= 1'b0;
            fill_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            clock_reg <= clock_next;
            done_reg  <= done_next;
            adm_reg   <= adm_next;
            left_reg  <= left_next;
            scan_reg  <= scan_next;
            vld_reg   <= vld_next;
            fill_reg  <= fill_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    always_ff @(posedge aclk) begin
        vidx_reg    <= vidx_next;
        pick_ok_reg <= pick_ok_next;
        pick_reg    <= pick_next;
        key_reg     <= key_next;
        na_ok_reg   <= na_ok_next;
        na_reg      <= na_next;
        cur_reg     <= cur_next;
        crem_reg    <= crem_next;
    end

    assign q_c   = (quantum_reg == 16'd0) ? 16'd1 : quantum_reg;
    assign arr_c = {7'd0, jr_job.arrival};
    assign k_c   = (mode_reg == cjs_pkg::MODE_FCFS) ? {1'b0, jr_job.arrival} :
                   (mode_reg == cjs_pkg::MODE_SJF)  ? {1'b0, jr_job.burst} :
                                                      {1'b0, jr_rem};
    assign ta_c  = jr_fin - arr_c;
    assign wt_c  = (ta_c > {7'd0, jr_job.burst}) ? ta_c - {7'd0, jr_job.burst} : '0;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        clock_next   = clock_reg;
        done_next    = done_reg;
        adm_next     = adm_reg;
        left_next    = left_reg;
        scan_next    = scan_reg;
        vld_next     = 1'b0;
        vidx_next    = scan_reg[IW-1:0];
        pick_ok_next = pick_ok_reg;
        pick_next    = pick_reg;
        key_next     = key_reg;
        na_ok_next   = na_ok_reg;
        na_next      = na_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        fill_next    = fill_reg;
        cur_next     = cur_reg;
        crem_next    = crem_reg;
        jw_en   = 1'b0;
        jw_addr = count_reg[IW-1:0];
        jw_job  = {s_tdata[5:0], s_tdata[21:6], s_tdata[37:22]};
        jw_rem  = s_tdata[37:22];
        jw_fin  = '0;
        jr_addr = scan_reg[IW-1:0];
        rw_en   = 1'b0;
        rw_addr = tail_reg;
        rw_data = vidx_reg;
        rr_addr = head_reg;
        s_tready = 1'b0;
        elig_c   = 1'b0;
        run_c    = '0;
        qrun_c   = '0;
        sum_c    = '0;

        case (state_reg)
            cjs_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (count_reg < CW'(cjs_pkg::MAX_JOBS)) begin
                        jw_en      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (s_tlast) begin
                        state_next = cjs_pkg::ST_INIT;
                    end
                end
            end
            cjs_pkg::ST_INIT: begin
                clock_next = '0;
                done_next  = '0;
                adm_next   = '0;
                left_next  = count_reg;
                head_next  = '0;
                tail_next  = '0;
                fill_next  = '0;
                scan_next  = '0;
                pick_ok_next = 1'b0;
                na_ok_next   = 1'b0;
                if (count_reg == '0) begin
                    state_next = cjs_pkg::ST_LOAD;
                end else if (mode_reg == cjs_pkg::MODE_RR) begin
                    state_next = cjs_pkg::ST_RR_ADMIT;
                end else begin
                    state_next = cjs_pkg::ST_SCAN;
                end
            end
            cjs_pkg::ST_SCAN: begin
                // Stream all entries; find pick and earliest future arrival.
                if (scan_reg < count_reg) begin
                    scan_next = scan_reg + 1'b1;
                    vld_next  = 1'b1;
                end
                if (vld_reg && !done_reg[vidx_reg]) begin
                    if (arr_c <= clock_reg) begin
                        if (!pick_ok_reg || k_c < key_reg) begin
                            pick_ok_next = 1'b1;
                            pick_next    = vidx_reg;
                            key_next     = k_c;
                        end
                    end else if (!na_ok_reg || jr_job.arrival < na_reg) begin
                        na_ok_next = 1'b1;
                        na_next    = jr_job.arrival;
                    end
                end
                if (!vld_reg && scan_reg == count_reg) begin
                    scan_next  = {1'b0, pick_reg};
                    state_next = cjs_pkg::ST_DECIDE;
                end
            end
            cjs_pkg::ST_DECIDE: begin
                // With no pick, jump to the next arrival; else wait for the pick's record, then run it.
                jr_addr = pick_reg;
                if (!pick_ok_reg) begin
                    if (na_ok_reg) clock_next = {7'd0, na_reg};
                    state_next = cjs_pkg::ST_SCAN;
                end else if (vld_reg) begin
                    run_c = {7'd0, jr_rem};
                    if (mode_reg == cjs_pkg::MODE_SRTF && na_ok_reg &&
                        ({7'd0, na_reg} - clock_reg) < run_c) begin
                        run_c = {7'd0, na_reg} - clock_reg;
                    end
                    sum_c = {1'b0, clock_reg} + {1'b0, run_c};
                    clock_next = sum_c[TW] ? cjs_pkg::TMAX : sum_c[TW-1:0];
                    jw_en   = 1'b1;
                    jw_addr = pick_reg;
                    jw_job  = jr_job;
                    jw_rem  = jr_rem - run_c[15:0];
                    jw_fin  = clock_next;
                    if (jw_rem == 16'd0) begin
                        done_next[pick_reg] = 1'b1;
                        left_next = left_reg - 1'b1;
                    end
                    state_next = cjs_pkg::ST_SCAN;
                end else begin
                    vld_next = 1'b1;
                end
                if (state_next == cjs_pkg::ST_SCAN) begin
                    scan_next    = '0;
                    pick_ok_next = 1'b0;
                    na_ok_next   = 1'b0;
                    if (left_next == '0) begin
                        state_next = cjs_pkg::ST_OUT_RD;
                    end
                end
            end
            cjs_pkg::ST_RR_ADMIT: begin
                // Repeated scans push the earliest unadmitted arrived job.
                if (scan_reg < count_reg) begin
                    scan_next = scan_reg + 1'b1;
                    vld_next  = 1'b1;
                end
                if (vld_reg && !adm_reg[vidx_reg]) begin
                    elig_c = arr_c <= clock_reg;
                    if (elig_c && (!pick_ok_reg || {1'b0, jr_job.arrival} < key_reg)) begin
                        pick_ok_next = 1'b1;
                        pick_next    = vidx_reg;
                        key_next     = {1'b0, jr_job.arrival};
                    end
                    if (!elig_c && (!na_ok_reg || jr_job.arrival < na_reg)) begin
                        na_ok_next = 1'b1;
                        na_next    = jr_job.arrival;
                    end
                end
                if (!vld_reg && scan_reg == count_reg) begin
                    scan_next    = '0;
                    pick_ok_next = 1'b0;
                    if (pick_ok_reg) begin
                        na_ok_next = 1'b0;
                        adm_next[pick_reg] = 1'b1;
                        rw_en   = 1'b1;
                        rw_data = pick_reg;
                        tail_next = tail_reg + 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end else if (left_reg == '0) begin
                        state_next = cjs_pkg::ST_OUT_RD;
                    end else begin
                        state_next = cjs_pkg::ST_RR_PUSH;
                    end
                end
            end
            cjs_pkg::ST_RR_PUSH: begin
                // Re-queue the preempted job, then pop or jump idle time.
                if (crem_reg != 16'd0) begin
                    rw_en   = 1'b1;
                    rw_data = cur_reg;
                    tail_next = tail_reg + 1'b1;
                    fill_next = fill_reg + 1'b1;
                    crem_next = '0;
                end else if (fill_reg == '0) begin
                    if (na_ok_reg) clock_next = {7'd0, na_reg};
                    na_ok_next = 1'b0;
                    state_next = cjs_pkg::ST_RR_ADMIT;
                end else begin
                    state_next = cjs_pkg::ST_RR_POP;
                end
            end
            cjs_pkg::ST_RR_POP: begin
                if (!vld_reg) begin
                    vld_next = 1'b1;
                end else begin
                    cur_next  = rr_data;
                    head_next = head_reg + 1'b1;
                    fill_next = fill_reg - 1'b1;
                    scan_next = {1'b0, rr_data};
                    state_next = cjs_pkg::ST_RR_RUN;
                end
            end
            cjs_pkg::ST_RR_RUN: begin
                jr_addr = cur_reg;
                if (!vld_reg) begin
                    vld_next = 1'b1;
                end else begin
                    qrun_c = (jr_rem < q_c) ? {7'd0, jr_rem} : {7'd0, q_c};
                    sum_c  = {1'b0, clock_reg} + {1'b0, qrun_c};
                    clock_next = sum_c[TW] ? cjs_pkg::TMAX : sum_c[TW-1:0];
                    jw_en   = 1'b1;
                    jw_addr = cur_reg;
                    jw_job  = jr_job;
                    jw_rem  = jr_rem - qrun_c[15:0];
                    jw_fin  = clock_next;
                    crem_next = jw_rem;
                    if (jw_rem == 16'd0) begin
                        done_next[cur_reg] = 1'b1;
                        left_next = left_reg - 1'b1;
                    end
                    scan_next    = '0;
                    pick_ok_next = 1'b0;
                    na_ok_next   = 1'b0;
                    state_next   = cjs_pkg::ST_RR_ADMIT;
                end
            end
            cjs_pkg::ST_OUT_RD: begin
                scan_next  = '0;
                jr_addr    = '0;
                state_next = cjs_pkg::ST_OUT_WAIT;
            end
            cjs_pkg::ST_OUT_WAIT: begin
                state_next = cjs_pkg::ST_OUT_SEND;
            end
            cjs_pkg::ST_OUT_SEND: begin
                if (m_tready) begin
                    scan_next = scan_reg + 1'b1;
                    jr_addr   = scan_next[IW-1:0];
                    if (scan_next == count_reg) begin
                        count_next = '0;
                        state_next = cjs_pkg::ST_LOAD;
                    end else begin
                        state_next = cjs_pkg::ST_OUT_WAIT;
                    end
                end
            end
            default: state_next = cjs_pkg::ST_LOAD;
        endcase
        // round robin: clear crem and cur at init (a finished slice leaves crem zero)
        if (state_reg == cjs_pkg::ST_INIT) begin
            crem_next = '0;
            cur_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == cjs_pkg::ST_OUT_WAIT) begin
            out_id_reg    <= jr_job.id;
            out_ta_reg    <= ta_c;
            out_wt_reg    <= wt_c;
            out_tlast_reg <= (scan_reg + 1'b1) == count_reg;
        end
    end

    assign m_tvalid = (state_reg == cjs_pkg::ST_OUT_SEND);
    assign m_tdata  = {4'd0, out_wt_reg, out_ta_reg, out_id_reg};
    assign m_tlast  = out_tlast_reg;

    a_no_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != cjs_pkg::ST_LOAD) |-> !s_tready)
        else $error("input taken while simulating");
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(cjs_pkg::MAX_JOBS))
        else $error("job count overflow");
    a_fill_max: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(cjs_pkg::MAX_JOBS))
        else $error("ring overflow");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
endmodule

@@ test/testbench.sv @@
// Testbench for the CPU job scheduler simulator: loads job sets under all four
// policies, predicts each set's turnaround and waiting times and checks every result.
// Depends on cjs_pkg and cpu_job_scheduler_sim.
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic [5:0]                 id;
        logic [cjs_pkg::TIME_W-1:0] turnaround;
        logic [cjs_pkg::TIME_W-1:0] waiting;
        logic                       last;
    } job_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = cjs_pkg::REG_POLICY;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tlast;

    cpu_job_scheduler_sim dut (.*);

    job_result_t expected_results[$];
    int          mismatches = 0;
    int          items_sent = 0;
    bit          calm = 1'b0;
    int          hold_ticket = 0;
    int          hold_len = 0;

    logic [1:0]  cur_mode = cjs_pkg::MODE_FCFS;
    int unsigned cur_quantum = 1;
    int unsigned set_id[cjs_pkg::MAX_JOBS], set_arr[cjs_pkg::MAX_JOBS];
    int unsigned set_bur[cjs_pkg::MAX_JOBS];
    int unsigned set_count = 0;
    int unsigned rem_time[cjs_pkg::MAX_JOBS], fin_time[cjs_pkg::MAX_JOBS];
    bit          done_flag[cjs_pkg::MAX_JOBS], admitted[cjs_pkg::MAX_JOBS];
    int unsigned sched_now;
    int unsigned ready_queue[$];

    initial forever #2 aclk = ~aclk;

    function automatic int unsigned sat_add(int unsigned a, int unsigned b);
        return (a + b > cjs_pkg::TMAX) ? cjs_pkg::TMAX : a + b;
    endfunction

    function automatic int unsigned next_arrival(bit use_admitted);
        int unsigned best;
        bit found;
        best = cjs_pkg::TMAX;
        found = 1'b0;
        for (int i = 0; i < set_count; i++) begin
            if (!(use_admitted ? admitted[i] : done_flag[i]) && (!found || set_arr[i] < best)) begin
                best = set_arr[i];
                found = 1'b1;
            end
        end
        return found ? best : sched_now;
    endfunction

    function automatic void admit_arrivals();
        int pick;
        forever begin
            pick = -1;
            for (int i = 0; i < set_count; i++)
                if (!admitted[i] && set_arr[i] <= sched_now &&
                    (pick < 0 || set_arr[i] < set_arr[pick]))
                    pick = i;
            if (pick < 0) return;
            admitted[pick] = 1'b1;
            if (ready_queue.size() < cjs_pkg::MAX_JOBS) ready_queue.push_back(pick);
        end
    endfunction

    function automatic int unsigned sort_key(int i);
        case (cur_mode)
            cjs_pkg::MODE_FCFS: return set_arr[i];
            cjs_pkg::MODE_SJF:  return set_bur[i];
            default:            return rem_time[i];
        endcase
    endfunction

    function automatic void schedule_set();
        int unsigned left, q, run, j, ta, wt;
        int pick;
        job_result_t r;
        left = set_count;
        q = (cur_quantum[15:0] != 0) ? cur_quantum[15:0] : 1;
        sched_now = 0;
        ready_queue.delete();
        for (int i = 0; i < set_count; i++) begin
            rem_time[i] = set_bur[i];
            done_flag[i] = 1'b0;
            admitted[i] = 1'b0;
            fin_time[i] = 0;
        end
        while (left > 0) begin
            if (cur_mode == cjs_pkg::MODE_RR) begin
                admit_arrivals();
                if (ready_queue.size() == 0) begin
                    sched_now = next_arrival(1'b1);
                    continue;
                end
                j = ready_queue.pop_front();
                run = rem_time[j] < q ? rem_time[j] : q;
                sched_now = sat_add(sched_now, run);
                rem_time[j] -= run;
                admit_arrivals();
                if (rem_time[j] > 0) begin
                    if (ready_queue.size() < cjs_pkg::MAX_JOBS) ready_queue.push_back(j);
                end else begin
                    done_flag[j] = 1'b1;
                    fin_time[j] = sched_now;
                    left--;
                end
                continue;
            end
            pick = -1;
            for (int i = 0; i < set_count; i++) begin
                if (done_flag[i] || set_arr[i] > sched_now) continue;
                if (pick < 0 || sort_key(i) < sort_key(pick)) pick = i;
            end
            if (pick < 0) begin
                sched_now = next_arrival(1'b0);
                continue;
            end
            run = rem_time[pick];
            if (cur_mode == cjs_pkg::MODE_SRTF)
                for (int i = 0; i < set_count; i++)
                    if (!done_flag[i] && set_arr[i] > sched_now && set_arr[i] - sched_now < run)
                        run = set_arr[i] - sched_now;
            sched_now = sat_add(sched_now, run);
            rem_time[pick] -= run;
            if (rem_time[pick] == 0) begin
                done_flag[pick] = 1'b1;
                fin_time[pick] = sched_now;
                left--;
            end
        end
        for (int k = 0; k < set_count; k++) begin
            ta = fin_time[k] - set_arr[k];
            if (ta > cjs_pkg::TMAX) ta = cjs_pkg::TMAX;
            wt = (ta > set_bur[k]) ? ta - set_bur[k] : 0;
            r.id = set_id[k];
            r.turnaround = ta;
            r.waiting = wt;
            r.last = (k + 1 == set_count);
            expected_results.push_back(r);
        end
        set_count = 0;
    endfunction

    function automatic void load_job(int unsigned id, int unsigned arr, int unsigned bur, bit last);
        if (set_count < cjs_pkg::MAX_JOBS) begin
            set_id[set_count] = id;
            set_arr[set_count] = arr;
            set_bur[set_count] = bur;
            set_count++;
        end
        if (last) schedule_set();
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        job_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                report("unexpected transfer, id", m_tdata[5:0], 0);
            end else begin
                e = expected_results.pop_front();
                if (m_tdata[5:0] !== e.id) report("job id", m_tdata[5:0], e.id);
                if (m_tdata[28:6] !== e.turnaround)
                    report("turnaround", m_tdata[28:6], e.turnaround);
                if (m_tdata[51:29] !== e.waiting) report("waiting", m_tdata[51:29], e.waiting);
                if (m_tlast !== e.last) report("last", m_tlast, e.last);
            end
        end
    end

    always @(posedge aclk) begin
        static int stall_left = 0;
        static int seen_ticket = 0;
        if (hold_ticket != seen_ticket) begin
            seen_ticket = hold_ticket;
            stall_left = hold_len;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_job(int unsigned id, int unsigned arr, int unsigned bur, bit last);
        int gap;
        gap = calm ? 0 : (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, bur[15:0], arr[15:0], id[5:0]};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        load_job(id[5:0], arr[15:0], bur[15:0], last);
    endtask

    task automatic finish_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        finish_sending();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, int unsigned value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[15:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == cjs_pkg::REG_POLICY) cur_mode = value[1:0];
        else cur_quantum = value[15:0];
    endtask

    task automatic set_policy(logic [1:0] mode, int unsigned quantum);
        wait_idle();
        write_reg(cjs_pkg::REG_POLICY, mode);
        write_reg(cjs_pkg::REG_QUANTUM, quantum);
        @(posedge aclk);
    endtask

    // ties at arrival 0, zero burst, extreme ids, arrivals and bursts
    task automatic test_each_policy();
        for (int m = 0; m < 4; m++) begin
            set_policy(m[1:0], 65535);
            send_job(63, 5, 3, 0);
            send_job(0, 0, 65535, 0);
            send_job(21, 0, 0, 0);
            send_job(42, 65535, 1, 1);
        end
    endtask

    // overflow beyond the set size, zero quantum acting as one slice unit
    task automatic test_overflow_zero_quantum();
        set_policy(cjs_pkg::MODE_RR, 0);
        for (int i = 0; i < cjs_pkg::MAX_JOBS + 2; i++)
            send_job(i, i % 3, 1 + i % 4, i == cjs_pkg::MAX_JOBS + 1);
    endtask

    task automatic test_random_sets();
        int unsigned n, arr, bur, q;
        logic [1:0] mode;
        while (items_sent < 430) begin
            mode = $urandom_range(0, 3);
            case ($urandom_range(0, 3))
                0:       q = 1;
                1:       q = 65535;
                default: q = $urandom_range(1, 10);
            endcase
            set_policy(mode, q);
            calm = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(2, 5)) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    arr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(0, 60);
                    if (mode == cjs_pkg::MODE_RR && q < 4096)
                        bur = $urandom_range(1, 12);
                    else
                        bur = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 65535)
                                                          : $urandom_range(1, 30);
                    send_job($urandom_range(0, 63), arr, bur, i == n - 1);
                end
            end
            calm = 1'b0;
        end
    endtask

    task automatic test_output_backpressure();
        set_policy(cjs_pkg::MODE_SRTF, 1);
        hold_len = 400;
        hold_ticket++;
        repeat (3)
            for (int i = 0; i < 4; i++)
                send_job($urandom_range(0, 63), $urandom_range(0, 20),
                         $urandom_range(1, 20), i == 3);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_each_policy();
        test_overflow_zero_quantum();
        test_output_backpressure();
        test_random_sets();
        wait_idle();
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #40000000;
        $display("FAIL");
        $finish;
    end
endmodule

@@ files.f @@
rtl/cjs_pkg.sv
rtl/cjs_job_ram.sv
rtl/cjs_ring_ram.sv
rtl/cpu_job_scheduler_sim.sv
test/testbench.sv
